>>> hdl/assert_macros.svh
// Assertion macros shared by the line edit buffer modules.
// Needs nothing else; files that check their own logic include it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LECB_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lecb: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define LECB_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lecb: next-cycle check failed");

`endif

>>> hdl/lecb_pkg.sv
// Types and constants of the line edit character buffer.
// Used by the result stage and the top level; depends on nothing.
package lecb_pkg;

   localparam int DEPTH_DEF    = 1024;
   localparam int MAX_READ_DEF = 64;

   localparam int BYTE_W = 8;
   localparam int FILL_W = 11;
   localparam int CNT_W  = 16;
   localparam int RC_W   = 7;
   localparam int CMD_W  = 2;

   localparam int CSR_AW = 1;
   localparam int CSR_DW = 11;

   localparam int REQ_TDATA_W = 16;
   localparam int RSP_BITS    = BYTE_W + CNT_W + FILL_W + CNT_W;
   localparam int RSP_TDATA_W = 56;

   localparam logic [CSR_AW-1:0] REG_IGNORE_BS = 1'd0;
   localparam logic [CSR_AW-1:0] REG_MAX_FILL  = 1'd1;

   localparam logic [FILL_W-1:0] MAX_FILL_RST = 11'd1024;
   localparam logic [CNT_W-1:0]  CNT_MAX      = 16'hFFFF;

   localparam logic [BYTE_W-1:0] CH_BS  = 8'h08;
   localparam logic [BYTE_W-1:0] CH_NL  = 8'h0A;
   localparam logic [BYTE_W-1:0] CH_NUL = 8'h00;

   typedef enum logic [CMD_W-1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_FLUSH = 2'd2
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PREP,
      ST_EMIT,
      ST_STAT
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_byte;
      logic              has_byte;
      logic              last;
      logic [CNT_W-1:0]  write_total;
      logic [FILL_W-1:0] fill;
      logic [CNT_W-1:0]  line_total;
   } rsp_type;

endpackage

>>> hdl/line_edit_char_buffer.sv
// Line edit character buffer: a ring of DEPTH bytes in one RAM with backspace editing
// and a count of pending line terminators, plus a MAX_READ-entry RAM that gathers the
// bytes of a read. A write or flush request gives one response. A read request scans
// the ring one byte per cycle through the single read port of the character RAM, then
// passes a setup state and delivers each gathered byte from the gather RAM whenever the
// response slot is free; a read that delivers nothing gives one status response
// instead. Every response of a read shows the state after the whole read. Ring contents
// need no clearing after reset, so requests are taken from the first cycle. Depends on
// lecb_pkg, lecb_ram, lecb_out and assert_macros.svh.
`include "assert_macros.svh"

module line_edit_char_buffer
   import lecb_pkg::*;
#(
   parameter int DEPTH    = DEPTH_DEF,
   parameter int MAX_READ = MAX_READ_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // data_byte[7:0], read_count[14:8], zero
   input  logic [CMD_W-1:0]       req_tuser,   // cmd[1:0]
   input  logic                   req_tlast,   // end_of_write
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // out_byte[7:0], write_total[23:8],
                                               // fill[34:24], line_total[50:35], zero
   output logic [0:0]             rsp_tuser,   // has_byte[0]
   output logic                   rsp_tlast,   // last
   // register writes
   input  logic                   csr_we,
   input  logic [CSR_AW-1:0]      csr_addr,
   input  logic [CSR_DW-1:0]      csr_wdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int SW = (AW > FILL_W ? AW : FILL_W) + 1;
   localparam int GW = MAX_READ > 1 ? $clog2(MAX_READ) : 1;
   localparam int NW = $clog2(MAX_READ + 1);
   localparam logic [SW-1:0] DEPTH_S = SW'(DEPTH);
   localparam logic [AW-1:0] LAST_IX = AW'(DEPTH - 1);

   state_type         state_ff, state_in;
   logic [AW-1:0]     head_ff, head_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0]  lines_ff, lines_in;
   logic [CNT_W-1:0]  cw_ff, cw_in;
   logic [AW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic              dvld_ff, dvld_in;
   logic [NW-1:0]     n_ff, n_in;
   logic [NW-1:0]     want_ff, want_in;
   logic [NW-1:0]     e_ff, e_in;
   logic              ign_bs_ff;
   logic [FILL_W-1:0] max_fill_ff;

   logic              req_fire;
   cmd_type           req_cmd;
   logic [BYTE_W-1:0] req_byte;
   logic [RC_W-1:0]   req_rc;
   logic [NW-1:0]     rc_cap;
   logic [SW-1:0]     limit;
   logic [SW-1:0]     wr_sum;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     head_inc;
   logic [AW-1:0]     rd_ptr_inc;
   logic [NW-1:0]     e_inc;
   logic [CNT_W-1:0]  lines_dec;
   logic              scan_done;
   logic              counted;
   logic [CNT_W-1:0]  cw_next;

   logic              cs_wr_en;
   logic              cs_rd_en;
   logic [AW-1:0]     cs_rd_addr;
   logic [BYTE_W-1:0] cs_rd_data;
   logic              gb_wr_en;
   logic              gb_rd_en;
   logic [GW-1:0]     gb_rd_addr;
   logic [BYTE_W-1:0] gb_rd_data;

   logic              rsp_free;
   logic              rsp_load;
   rsp_type           rsp_next;
   rsp_type           rsp_item;

   assign req_cmd  = cmd_type'(req_tuser);
   assign req_byte = req_tdata[7:0];
   assign req_rc   = req_tdata[14:8];

   assign req_tready = (state_ff == ST_IDLE) && rsp_free;
   assign req_fire   = req_tvalid && req_tready;

   assign rc_cap = (req_rc > RC_W'(MAX_READ)) ? NW'(MAX_READ) : NW'(req_rc);
   assign limit  = (SW'(max_fill_ff) < DEPTH_S) ? SW'(max_fill_ff) : DEPTH_S;

   // Append position wraps once at most, since head stays below DEPTH and fill is at most DEPTH.
   assign wr_sum  = SW'(head_ff) + SW'(fill_ff);
   assign wr_addr = (wr_sum >= DEPTH_S) ? AW'(wr_sum - DEPTH_S) : AW'(wr_sum);

   assign head_inc   = (head_ff == LAST_IX) ? '0 : head_ff + AW'(1);
   assign rd_ptr_inc = (rd_ptr_ff == LAST_IX) ? '0 : rd_ptr_ff + AW'(1);
   assign e_inc      = e_ff + NW'(1);
   assign lines_dec  = (lines_ff == '0) ? '0 : lines_ff - CNT_W'(1);
   assign scan_done  = (fill_ff == '0) || (n_ff == want_ff);

   always_comb begin
      state_in   = state_ff;
      head_in    = head_ff;
      fill_in    = fill_ff;
      lines_in   = lines_ff;
      cw_in      = cw_ff;
      rd_ptr_in  = rd_ptr_ff;
      dvld_in    = 1'b0;
      n_in       = n_ff;
      want_in    = want_ff;
      e_in       = e_ff;
      counted    = 1'b0;
      cw_next    = cw_ff;
      cs_wr_en   = 1'b0;
      cs_rd_en   = 1'b0;
      cs_rd_addr = rd_ptr_ff;
      gb_wr_en   = 1'b0;
      gb_rd_en   = 1'b0;
      gb_rd_addr = e_inc[GW-1:0];
      rsp_load   = 1'b0;

      rsp_next.out_byte    = '0;
      rsp_next.has_byte    = 1'b0;
      rsp_next.last        = 1'b1;
      rsp_next.write_total = cw_ff;
      rsp_next.fill        = fill_ff;
      rsp_next.line_total  = lines_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_WRITE: begin
                     if (req_byte == CH_BS && !ign_bs_ff) begin
                        // Backspace erases the newest byte; a terminator stays counted.
                        if (fill_ff != '0) begin
                           fill_in = fill_ff - FILL_W'(1);
                           counted = 1'b1;
                        end
                     end else if (SW'(fill_ff) < limit) begin
                        cs_wr_en = 1'b1;
                        fill_in  = fill_ff + FILL_W'(1);
                        counted  = 1'b1;
                        if ((req_byte == CH_NL || req_byte == CH_NUL) &&
                            lines_ff != CNT_MAX) begin
                           lines_in = lines_ff + CNT_W'(1);
                        end
                     end
                     if (counted && cw_ff != CNT_MAX) begin
                        cw_next = cw_ff + CNT_W'(1);
                     end
                     cw_in                = req_tlast ? '0 : cw_next;
                     rsp_load             = 1'b1;
                     rsp_next.write_total = cw_next;
                     rsp_next.fill        = fill_in;
                     rsp_next.line_total  = lines_in;
                  end
                  CMD_READ: begin
                     // Fetch the front byte now so the scan has data in its first cycle.
                     cs_rd_en   = 1'b1;
                     cs_rd_addr = head_ff;
                     rd_ptr_in  = head_inc;
                     dvld_in    = 1'b1;
                     n_in       = '0;
                     want_in    = rc_cap;
                     state_in   = ST_SCAN;
                  end
                  CMD_FLUSH: begin
                     fill_in             = '0;
                     lines_in            = '0;
                     head_in             = '0;
                     rsp_load            = 1'b1;
                     rsp_next.fill       = '0;
                     rsp_next.line_total = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_done) begin
               state_in = (n_ff == '0) ? ST_STAT : ST_PREP;
            end else begin
               // Read ahead every cycle; the data of the previous fetch belongs to head.
               cs_rd_en  = 1'b1;
               rd_ptr_in = rd_ptr_inc;
               dvld_in   = 1'b1;
               if (dvld_ff) begin
                  head_in = head_inc;
                  fill_in = fill_ff - FILL_W'(1);
                  if (cs_rd_data == CH_NUL) begin
                     lines_in = lines_dec;
                  end else begin
                     gb_wr_en = 1'b1;
                     n_in     = n_ff + NW'(1);
                     if (cs_rd_data == CH_NL) begin
                        lines_in = lines_dec;
                     end
                  end
               end
            end
         end
         ST_PREP: begin
            gb_rd_en   = 1'b1;
            gb_rd_addr = '0;
            e_in       = '0;
            state_in   = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_free) begin
               rsp_load          = 1'b1;
               rsp_next.out_byte = gb_rd_data;
               rsp_next.has_byte = 1'b1;
               rsp_next.last     = (e_inc == n_ff);
               if (e_inc == n_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  e_in     = e_inc;
                  gb_rd_en = 1'b1;
               end
            end
         end
         ST_STAT: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         head_ff   <= '0;
         fill_ff   <= '0;
         lines_ff  <= '0;
         cw_ff     <= '0;
         dvld_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         head_ff   <= head_in;
         fill_ff   <= fill_in;
         lines_ff  <= lines_in;
         cw_ff     <= cw_in;
         dvld_ff   <= dvld_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff <= rd_ptr_in;
      n_ff      <= n_in;
      want_ff   <= want_in;
      e_ff      <= e_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ign_bs_ff   <= 1'b0;
         max_fill_ff <= MAX_FILL_RST;
      end else if (csr_we) begin
         case (csr_addr)
            REG_IGNORE_BS: ign_bs_ff   <= csr_wdata[0];
            REG_MAX_FILL:  max_fill_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   lecb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_char_ram (
      .clock   (clock),
      .wr_en   (cs_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_byte),
      .rd_en   (cs_rd_en),
      .rd_addr (cs_rd_addr),
      .rd_data (cs_rd_data)
   );

   lecb_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_READ)
   ) u_gather_ram (
      .clock   (clock),
      .wr_en   (gb_wr_en),
      .wr_addr (n_ff[GW-1:0]),
      .wr_data (cs_rd_data),
      .rd_en   (gb_rd_en),
      .rd_addr (gb_rd_addr),
      .rd_data (gb_rd_data)
   );

   lecb_out u_out (
      .clock   (clock),
      .reset   (reset),
      .load_i  (rsp_load),
      .item_i  (rsp_next),
      .ready_i (rsp_tready),
      .free_o  (rsp_free),
      .valid_o (rsp_tvalid),
      .item_o  (rsp_item)
   );

   assign rsp_tdata = {{(RSP_TDATA_W - RSP_BITS){1'b0}}, rsp_item.line_total,
                       rsp_item.fill, rsp_item.write_total, rsp_item.out_byte};
   assign rsp_tuser = rsp_item.has_byte;
   assign rsp_tlast = rsp_item.last;

   `LECB_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, SW'(fill_ff) <= DEPTH_S)
   `LECB_ASSERT_IMP(a_scan_count, clock, reset, state_ff == ST_SCAN, n_ff <= want_ff)
   `LECB_ASSERT_NEXT(a_last_idle, clock, reset, rsp_load && rsp_next.last,
      state_ff == ST_IDLE)

endmodule

>>> hdl/lecb_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed. Read data holds while rd_en is low.
module lecb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/lecb_out.sv
// Result register of the line edit buffer: holds one response until taken.
// Depends on lecb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lecb_out
   import lecb_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    load_i,
   input  rsp_type item_i,
   input  logic    ready_i,
   output logic    free_o,
   output logic    valid_o,
   output rsp_type item_o
);

   logic    vld_ff;
   logic    vld_in;
   rsp_type item_ff;

   // The slot can take a new response when empty or when the current one leaves now.
   assign free_o = !vld_ff || ready_i;

   always_comb begin
      vld_in = vld_ff;
      if (load_i) begin
         vld_in = 1'b1;
      end else if (ready_i) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_i) begin
         item_ff <= item_i;
      end
   end

   assign valid_o = vld_ff;
   assign item_o  = item_ff;

   `LECB_ASSERT_IMP(a_no_overrun, clock, reset, load_i, !vld_ff || ready_i)
   `LECB_ASSERT_NEXT(a_load_shows, clock, reset, load_i, vld_ff)

endmodule

>>> dv/tb_line_edit_char_buffer.sv
// Self-checking testbench for the line edit character buffer: directed and random requests
// are checked against a behavioral model of the edit queue kept inside the bench.
// Depends on lecb_pkg and the line_edit_char_buffer RTL.
module tb_line_edit_char_buffer
   import lecb_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;     // data_byte[7:0], read_count[14:8], zero
   logic [CMD_W-1:0]       req_tuser  = CMD_WRITE;  // cmd[1:0]
   logic                   req_tlast  = 1'b0;   // end_of_write
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;           // out_byte[7:0], write_total[23:8],
                                                // fill[34:24], line_total[50:35], zero
   logic [0:0]             rsp_tuser;           // has_byte[0]
   logic                   rsp_tlast;           // last
   logic                   csr_we     = 1'b0;
   logic [CSR_AW-1:0]      csr_addr   = REG_IGNORE_BS;
   logic [CSR_DW-1:0]      csr_wdata  = '0;

   line_edit_char_buffer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Behavioral copy of the edit queue and its registers.
   logic [BYTE_W-1:0] ring_mem [DEPTH_DEF];
   int ring_head  = 0;
   int ring_fill  = 0;
   int line_count = 0;
   int call_bytes = 0;
   bit ign_bs     = 1'b0;
   int fill_cap   = DEPTH_DEF;

   rsp_type expected_rsp[$];
   int      errors = 0;

   // Sender pacing and receiver stall control.
   bit gaps_on    = 1'b1;
   int burst_left = 0;
   int hold_asks  = 0;
   int hold_seen  = 0;
   int hold_left  = 0;
   int stall_mode = 0;
   int window     = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("** line_edit_char_buffer: FAILED **");
      $finish;
   end

   function automatic rsp_type snapshot_rsp(logic [BYTE_W-1:0] b, logic has, logic lst);
      rsp_type r;
      r.out_byte    = b;
      r.has_byte    = has;
      r.last        = lst;
      r.write_total = call_bytes[CNT_W-1:0];
      r.fill        = ring_fill[FILL_W-1:0];
      r.line_total  = line_count[CNT_W-1:0];
      return r;
   endfunction

   // Applies one request to the queue copy and queues the responses it must produce.
   task automatic predict_edit(cmd_type cmd, logic [BYTE_W-1:0] ch, logic eow,
                               logic [RC_W-1:0] rc);
      int                limit;
      int                want;
      bit                counted;
      logic [BYTE_W-1:0] c;
      logic [BYTE_W-1:0] taken[$];
      case (cmd)
         CMD_WRITE: begin
            limit   = (fill_cap < DEPTH_DEF) ? fill_cap : DEPTH_DEF;
            counted = 1'b0;
            if (ch == CH_BS && !ign_bs) begin
               if (ring_fill > 0) begin
                  ring_fill--;
                  counted = 1'b1;
               end
            end else if (ring_fill < limit) begin
               ring_mem[(ring_head + ring_fill) % DEPTH_DEF] = ch;
               ring_fill++;
               counted = 1'b1;
               if ((ch == CH_NL || ch == CH_NUL) && line_count < 65535)
                  line_count++;
            end
            if (counted && call_bytes < 65535)
               call_bytes++;
            expected_rsp.push_back(snapshot_rsp('0, 1'b0, 1'b1));
            if (eow)
               call_bytes = 0;
         end
         CMD_READ: begin
            want = (int'(rc) > MAX_READ_DEF) ? MAX_READ_DEF : int'(rc);
            while (ring_fill > 0 && taken.size() < want) begin
               c         = ring_mem[ring_head];
               ring_head = (ring_head + 1) % DEPTH_DEF;
               ring_fill--;
               if (c == CH_NL || c == CH_NUL) begin
                  if (line_count > 0)
                     line_count--;
               end
               // NULs are consumed but never handed out.
               if (c != CH_NUL)
                  taken.push_back(c);
            end
            if (taken.size() == 0)
               expected_rsp.push_back(snapshot_rsp('0, 1'b0, 1'b1));
            else
               foreach (taken[k])
                  expected_rsp.push_back(snapshot_rsp(taken[k], 1'b1, k == taken.size() - 1));
         end
         CMD_FLUSH: begin
            ring_fill  = 0;
            line_count = 0;
            ring_head  = 0;
            expected_rsp.push_back(snapshot_rsp('0, 1'b0, 1'b1));
         end
         default: begin
            expected_rsp.push_back(snapshot_rsp('0, 1'b0, 1'b1));
         end
      endcase
   endtask

   task automatic report_mismatch(string what, longint exp_v, longint got_v);
      errors++;
      if (errors <= 30)
         $display("mismatch at %0t: %s expected %0h got %0h", $time, what, exp_v, got_v);
   endtask

   task automatic check_rsp();
      rsp_type want;
      rsp_type got;
      got.out_byte    = rsp_tdata[7:0];
      got.write_total = rsp_tdata[23:8];
      got.fill        = rsp_tdata[34:24];
      got.line_total  = rsp_tdata[50:35];
      got.has_byte    = rsp_tuser[0];
      got.last        = rsp_tlast;
      if (expected_rsp.size() == 0) begin
         report_mismatch("response with nothing outstanding", 0, got.out_byte);
      end else begin
         want = expected_rsp.pop_front();
         if (got.out_byte != want.out_byte)
            report_mismatch("out_byte", want.out_byte, got.out_byte);
         if (got.has_byte != want.has_byte)
            report_mismatch("has_byte", want.has_byte, got.has_byte);
         if (got.last != want.last)
            report_mismatch("last", want.last, got.last);
         if (got.write_total != want.write_total)
            report_mismatch("write_total", want.write_total, got.write_total);
         if (got.fill != want.fill)
            report_mismatch("fill", want.fill, got.fill);
         if (got.line_total != want.line_total)
            report_mismatch("line_total", want.line_total, got.line_total);
      end
   endtask

   // Response side: check what was taken at this edge, then pick readiness for the next.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         check_rsp();
      if (hold_asks != hold_seen) begin
         hold_seen = hold_asks;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (window == 0) begin
            stall_mode = $urandom_range(0, 3);
            window     = $urandom_range(20, 80);
         end else begin
            window--;
         end
         case (stall_mode)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            2: rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   // Offers one request and returns at the edge where it is accepted (or after a gap).
   task automatic send_req(cmd_type cmd, logic [BYTE_W-1:0] ch, logic eow,
                           logic [RC_W-1:0] rc);
      req_tuser <= cmd;
      req_tdata <= REQ_TDATA_W'({rc, ch});
      req_tlast <= eow;
      if (!req_tvalid)
         req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_edit(cmd, ch, eow, rc);
      if (gaps_on) begin
         if (burst_left > 0) begin
            burst_left--;
         end else begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(0, 12);
         end
      end
   endtask

   task automatic write_byte(logic [BYTE_W-1:0] ch, logic eow);
      send_req(CMD_WRITE, ch, eow, RC_W'(1));
   endtask

   task automatic read_bytes(logic [RC_W-1:0] rc);
      send_req(CMD_READ, '0, 1'b0, rc);
   endtask

   task automatic wait_drained();
      if (req_tvalid)
         req_tvalid <= 1'b0;
      while (expected_rsp.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_AW-1:0] idx, logic [CSR_DW-1:0] val);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == REG_IGNORE_BS)
         ign_bs = val[0];
      else if (idx == REG_MAX_FILL)
         fill_cap = int'(val);
   endtask

   task automatic set_config(bit ignore, int cap);
      wait_drained();
      write_reg(REG_IGNORE_BS, CSR_DW'(ignore));
      write_reg(REG_MAX_FILL, CSR_DW'(cap));
   endtask

   function automatic logic [BYTE_W-1:0] random_char();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) return CH_BS;
      if (pick < 17) return CH_NL;
      if (pick < 21) return CH_NUL;
      if (pick < 31) return BYTE_W'($urandom);
      return BYTE_W'($urandom_range(8'h20, 8'h7E));
   endfunction

   function automatic logic [RC_W-1:0] random_count();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return RC_W'($urandom_range(1, 8));
      if (pick < 85) return RC_W'($urandom_range(1, MAX_READ_DEF));
      return RC_W'(MAX_READ_DEF);
   endfunction

   task automatic test_directed();
      write_byte(CH_BS, 1'b0);       // nothing to erase yet
      write_byte(8'h61, 1'b0);
      write_byte(8'hFF, 1'b0);
      write_byte(CH_NUL, 1'b0);
      write_byte(CH_NL, 1'b0);
      write_byte(8'h80, 1'b0);
      write_byte(CH_BS, 1'b0);
      write_byte(CH_BS, 1'b0);       // erases a newline; the line count stays
      write_byte(CH_NL, 1'b1);
      read_bytes(RC_W'(1));
      read_bytes(RC_W'(MAX_READ_DEF));
      read_bytes(RC_W'(MAX_READ_DEF));
      write_byte(8'h62, 1'b0);
      write_byte(CH_NUL, 1'b1);
      read_bytes(RC_W'(1));          // the trailing NUL must stay queued
      read_bytes(RC_W'(1));          // consumes only the NUL
      write_byte(8'h78, 1'b0);
      write_byte(CH_NL, 1'b1);
      send_req(CMD_FLUSH, 8'hC3, 1'b1, RC_W'(MAX_READ_DEF));
      read_bytes(RC_W'(MAX_READ_DEF));
      write_byte(8'h55, 1'b0);
      write_byte(8'hAA, 1'b1);
      read_bytes(RC_W'(0));          // a zero count consumes nothing
      read_bytes(RC_W'(100));        // a count above the read limit is capped
   endtask

   task automatic test_registers();
      set_config(1'b0, 0);
      write_byte(8'h71, 1'b0);
      write_byte(CH_BS, 1'b1);
      set_config(1'b0, 3);
      write_byte(8'h31, 1'b0);
      write_byte(8'h32, 1'b0);
      write_byte(CH_NL, 1'b0);
      write_byte(8'h34, 1'b0);       // dropped at the fill limit
      write_byte(CH_BS, 1'b0);       // erasing still works at the limit
      write_byte(8'h7A, 1'b1);
      read_bytes(RC_W'(MAX_READ_DEF));
      set_config(1'b1, 3);
      write_byte(CH_BS, 1'b0);
      write_byte(CH_BS, 1'b1);
      read_bytes(RC_W'(MAX_READ_DEF));
      set_config(1'b0, DEPTH_DEF);
   endtask

   // The receiver holds off long enough for the block to back up its request side.
   task automatic test_backpressure();
      wait_drained();
      gaps_on = 1'b0;
      hold_asks++;
      for (int i = 0; i < 40; i++)
         write_byte(random_char(), i == 39);
      read_bytes(RC_W'(MAX_READ_DEF));
      gaps_on = 1'b1;
      wait_drained();
   endtask

   // Mostly typed lines with edits, ended by a terminator and often followed by a read;
   // the rest are loose requests of any kind.
   task automatic run_random(int n_items);
      int      done;
      int      len;
      int      pick;
      cmd_type cmd;
      done = 0;
      while (done < n_items) begin
         gaps_on = ($urandom_range(0, 4) != 0);
         if ($urandom_range(0, 99) < 70) begin
            len = $urandom_range(1, 10);
            for (int i = 0; i < len; i++)
               write_byte(random_char(), $urandom_range(0, 9) == 0);
            write_byte(($urandom_range(0, 4) == 0) ? CH_NUL : CH_NL, 1'b1);
            done += len + 1;
            if ($urandom_range(0, 99) < 60) begin
               read_bytes(random_count());
               done++;
            end
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
               cmd = CMD_WRITE;
            else if (pick < 93)
               cmd = CMD_READ;
            else
               cmd = CMD_FLUSH;
            send_req(cmd, BYTE_W'($urandom), 1'($urandom), random_count());
            done++;
         end
      end
      gaps_on = 1'b1;
   endtask

   task automatic test_random_phases();
      set_config(1'b0, DEPTH_DEF);
      run_random(120);
      set_config(1'b1, 16);
      run_random(90);
      set_config(1'b0, 5);
      run_random(80);
      set_config(1'b1, DEPTH_DEF);
      run_random(70);
      set_config(1'b0, DEPTH_DEF);
      run_random(15);
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_registers();
      test_backpressure();
      test_random_phases();
      wait_drained();
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("** line_edit_char_buffer: PASSED **");
      else
         $display("** line_edit_char_buffer: FAILED **");
      $finish;
   end

endmodule
